### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define HRHP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define HRHP_NEVER(lbl, clk, rstn, prop) \
  `HRHP_ASSERT(lbl, clk, rstn, !(prop))

`endif

### rtl/hrhp_pkg.sv
package hrhp_pkg;

  localparam int unsigned MaxHeadersDef      = 16;
  localparam int unsigned NameBytesDef       = 64;
  localparam int unsigned ValueBytesDef      = 256;
  localparam int unsigned StatusTextBytesDef = 64;

  // byte role codes
  localparam logic [2:0] RoleNone  = 3'd0;
  localparam logic [2:0] RoleText  = 3'd1;
  localparam logic [2:0] RoleName  = 3'd2;
  localparam logic [2:0] RoleValue = 3'd3;
  localparam logic [2:0] RoleType  = 3'd4;

  // candidate header names, bit positions in the candidate mask
  localparam int unsigned CandLen  = 0;
  localparam int unsigned CandType = 1;
  localparam int unsigned CandTe   = 2;
  localparam int unsigned CandCount = 3;

  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharLowC  = 8'h63;

  localparam int unsigned PrefixLen = 7;
  localparam int unsigned MinBlock  = 12;
  localparam int unsigned CodeStart = 9;
  localparam logic [2:0]  ChunkFull = 3'd7;

  // lower-case names, padded to the longest one
  localparam logic [8*17-1:0] CandStrLen  = "content-length   ";
  localparam logic [8*17-1:0] CandStrType = "content-type     ";
  localparam logic [8*17-1:0] CandStrTe   = "transfer-encoding";

  typedef enum logic [6:0] {
    PhPrefix = 7'b0000001,
    PhSeek   = 7'b0000010,
    PhText   = 7'b0000100,
    PhEol    = 7'b0001000,
    PhName   = 7'b0010000,
    PhGap    = 7'b0100000,
    PhValue  = 7'b1000000
  } phase_e;

  typedef enum logic [3:0] {
    NumLead = 4'b0001,
    NumPos  = 4'b0010,
    NumNeg  = 4'b0100,
    NumDone = 4'b1000
  } num_e;

  function automatic logic [7:0] lower_char(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CharZero && c <= CharNine;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = "H";
      3'd1:    c = "T";
      3'd2:    c = "T";
      3'd3:    c = "P";
      3'd4:    c = "/";
      3'd5:    c = "1";
      3'd6:    c = ".";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] chunk_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = "c";
      3'd1:    c = "h";
      3'd2:    c = "u";
      3'd3:    c = "n";
      3'd4:    c = "k";
      3'd5:    c = "e";
      3'd6:    c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] cand_len(input int unsigned which);
    logic [4:0] n;
    unique case (which)
      CandLen:  n = 5'd14;
      CandType: n = 5'd12;
      default:  n = 5'd17;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] cand_char(input int unsigned which, input logic [4:0] pos);
    logic [4:0]        p;
    logic [8*17-1:0]   s;
    p = (pos > 5'd16) ? 5'd16 : pos;
    unique case (which)
      CandLen:  s = CandStrLen;
      CandType: s = CandStrType;
      default:  s = CandStrTe;
    endcase
    return s[8*(16-p) +: 8];
  endfunction

  // next phase of the decimal number reader
  function automatic num_e num_step(input num_e np, input logic [7:0] c);
    num_e n;
    n = np;
    if (np == NumLead) begin
      if (c == CharSpace || (c >= 8'd9 && c <= 8'd13)) n = NumLead;
      else if (c == CharPlus)  n = NumPos;
      else if (c == CharMinus) n = NumNeg;
      else if (is_digit(c))    n = NumPos;
      else                     n = NumDone;
    end else if (np != NumDone && !is_digit(c)) begin
      n = NumDone;
    end
    return n;
  endfunction

  // digit goes into the accumulator
  function automatic logic num_takes(input num_e np, input logic [7:0] c);
    return is_digit(c) && (np == NumLead || np == NumPos);
  endfunction

endpackage

### rtl/hrhp_in_if.sv
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

### rtl/hrhp_out_if.sv
interface hrhp_out_if #(
  parameter int unsigned SLOT_W  = 4,
  parameter int unsigned TOTAL_W = 5
);
  logic               valid;
  logic               ready;
  logic [2:0]         byte_role;
  logic [7:0]         echo_byte;
  logic [SLOT_W-1:0]  header_slot;
  logic               done_res;
  logic               parse_error;
  logic [15:0]        resp_code;
  logic [31:0]        body_length;
  logic               chunked_seen;
  logic [TOTAL_W-1:0] header_total;

  modport source (
    output valid, byte_role, echo_byte, header_slot, done_res, parse_error, resp_code,
           body_length, chunked_seen, header_total,
    input  ready
  );
  modport sink (
    input  valid, byte_role, echo_byte, header_slot, done_res, parse_error, resp_code,
           body_length, chunked_seen, header_total,
    output ready
  );
endinterface

### rtl/hrhp_pipe_reg.sv
module hrhp_pipe_reg #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic         valid_q;
  logic [W-1:0] data_q;

  // slot frees up when empty or when its item leaves in this cycle
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/hrhp_parse_core.sv
module hrhp_parse_core import hrhp_pkg::*; #(
  parameter int unsigned MAX_HEADERS       = MaxHeadersDef,
  parameter int unsigned NAME_BYTES        = NameBytesDef,
  parameter int unsigned VALUE_BYTES       = ValueBytesDef,
  parameter int unsigned STATUS_TEXT_BYTES = StatusTextBytesDef,
  localparam int unsigned SLOT_W  = (MAX_HEADERS > 1) ? $clog2(MAX_HEADERS) : 1,
  localparam int unsigned HDR_W   = $clog2(MAX_HEADERS + 1),
  localparam int unsigned TEXT_W  = $clog2(STATUS_TEXT_BYTES),
  localparam int unsigned NAME_W  = $clog2(NAME_BYTES),
  localparam int unsigned VALUE_W = $clog2(VALUE_BYTES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output logic [2:0]        role_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic              done_o,
  output logic              error_o,
  output logic [15:0]       code_o,
  output logic [31:0]       length_o,
  output logic              chunked_o,
  output logic [HDR_W-1:0]  total_o
);

  phase_e               phase_q, phase_d;
  logic [3:0]           off_q, off_d;
  logic                 pg_q, pg_d;
  logic [15:0]          code_q, code_d;
  logic                 open_q, open_d;
  logic [TEXT_W-1:0]    text_q, text_d;
  logic [NAME_W-1:0]    name_q, name_d;
  logic [VALUE_W-1:0]   value_q, value_d;
  logic [CandCount-1:0] cand_q, cand_d;
  logic [2:0]           chunk_q, chunk_d;
  logic [31:0]          lacc_q, lacc_d;
  num_e                 num_q, num_d;
  logic [31:0]          kept_q, kept_d;
  logic                 chunked_q, chunked_d;
  logic [HDR_W-1:0]     hdr_q, hdr_d;

  function automatic logic [15:0] code_sat(input logic [15:0] a, input logic [3:0] dig);
    logic [19:0] v;
    v = ({4'd0, a} << 3) + ({4'd0, a} << 1) + {16'd0, dig};
    return (v > 20'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [31:0] len_sat(input logic [31:0] a, input logic [3:0] dig);
    logic [35:0] v;
    v = ({4'd0, a} << 3) + ({4'd0, a} << 1) + {32'd0, dig};
    return (v > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  always_comb begin
    phase_e ph;
    logic   skip;
    logic   fin;
    logic   eol;
    logic   storing;
    logic   bad;

    phase_d   = phase_q;
    pg_d      = pg_q;
    code_d    = code_q;
    open_d    = open_q;
    text_d    = text_q;
    name_d    = name_q;
    value_d   = value_q;
    cand_d    = cand_q;
    chunk_d   = chunk_q;
    lacc_d    = lacc_q;
    num_d     = num_q;
    kept_d    = kept_q;
    chunked_d = chunked_q;
    hdr_d     = hdr_q;
    role_o    = RoleNone;
    slot_o    = '0;
    skip      = 1'b0;
    fin       = 1'b0;
    eol       = (byte_i == CharCr) || (byte_i == CharLf);
    storing   = pg_q && (hdr_q < HDR_W'(MAX_HEADERS));

    // status number reader runs alongside the phase logic
    if (open_q && off_q >= 4'(CodeStart)) begin
      if (num_takes(num_d, byte_i)) code_d = code_sat(code_q, byte_i[3:0]);
      num_d = num_step(num_d, byte_i);
      if (num_d == NumDone) open_d = 1'b0;
    end

    ph = phase_q;
    if (ph == PhEol) begin
      if (eol) begin
        skip = 1'b1;
      end else begin
        ph     = PhName;
        name_d = '0;
        cand_d = '1;
      end
    end else if (ph == PhGap) begin
      if (byte_i == CharSpace || byte_i == CharTab) skip = 1'b1;
      else ph = PhValue;
    end

    if (!skip) begin
      unique case (ph)
        PhPrefix: begin
          if (off_q < 4'(PrefixLen) && byte_i != prefix_char(off_q[2:0])) pg_d = 1'b0;
          if (off_q >= 4'd8) ph = PhSeek;
        end
        PhSeek: begin
          if (byte_i == CharSpace) ph = PhText;
        end
        PhText: begin
          if (eol) begin
            ph = PhEol;
          end else if (pg_q && text_q < TEXT_W'(STATUS_TEXT_BYTES - 1)) begin
            role_o = RoleText;
            text_d = text_q + TEXT_W'(1);
          end
        end
        PhName: begin
          if (byte_i == CharColon) begin
            for (int unsigned i = 0; i < CandCount; i++) begin
              if (name_d != NAME_W'(cand_len(i))) cand_d[i] = 1'b0;
            end
            value_d = '0;
            chunk_d = '0;
            if (cand_d[CandLen]) begin
              num_d  = NumLead;
              lacc_d = '0;
            end
            ph = PhGap;
          end else if (storing && name_d < NAME_W'(NAME_BYTES - 1)) begin
            role_o = RoleName;
            slot_o = hdr_q[SLOT_W-1:0];
            for (int unsigned i = 0; i < CandCount; i++) begin
              if (name_d >= NAME_W'(cand_len(i)) ||
                  lower_char(byte_i) != cand_char(i, name_d[4:0])) begin
                cand_d[i] = 1'b0;
              end
            end
            name_d = name_d + NAME_W'(1);
          end
        end
        PhValue: begin
          if (eol) begin
            fin = 1'b1;
            ph  = PhEol;
          end else if (storing && value_q < VALUE_W'(VALUE_BYTES - 1)) begin
            role_o = cand_d[CandType] ? RoleType : RoleValue;
            slot_o = hdr_q[SLOT_W-1:0];
            // substring search, restarting on a fresh 'c'
            if (cand_d[CandTe] && chunk_q < ChunkFull) begin
              if (byte_i == chunk_char(chunk_q)) chunk_d = chunk_q + 3'd1;
              else if (byte_i == CharLowC)       chunk_d = 3'd1;
              else                               chunk_d = 3'd0;
            end
            if (cand_d[CandLen]) begin
              if (num_takes(num_d, byte_i)) lacc_d = len_sat(lacc_d, byte_i[3:0]);
              num_d = num_step(num_d, byte_i);
            end
            value_d = value_q + VALUE_W'(1);
          end
        end
        default: ;
      endcase
    end

    phase_d = ph;
    off_d   = (off_q == 4'hF) ? off_q : off_q + 4'd1;

    // a header cut off by the end of the block still counts
    if (last_i && (ph == PhGap || ph == PhValue)) fin = 1'b1;

    if (fin && hdr_d < HDR_W'(MAX_HEADERS)) begin
      if (cand_d[CandLen]) kept_d = (num_d == NumNeg) ? 32'd0 : lacc_d;
      if (cand_d[CandTe] && chunk_d == ChunkFull) chunked_d = 1'b1;
      hdr_d = hdr_d + HDR_W'(1);
    end

    bad       = !pg_d || (off_d < 4'(MinBlock));
    done_o    = last_i;
    error_o   = last_i && bad;
    code_o    = (last_i && !bad) ? code_d : 16'd0;
    length_o  = (last_i && !bad) ? kept_d : 32'd0;
    chunked_o = last_i && !bad && chunked_d;
    total_o   = (last_i && !bad) ? hdr_d : '0;

    // next block starts from a clean state
    if (last_i) begin
      phase_d   = PhPrefix;
      off_d     = 4'd0;
      pg_d      = 1'b1;
      code_d    = 16'd0;
      open_d    = 1'b1;
      text_d    = '0;
      name_d    = '0;
      value_d   = '0;
      cand_d    = '1;
      chunk_d   = 3'd0;
      lacc_d    = 32'd0;
      num_d     = NumLead;
      kept_d    = 32'd0;
      chunked_d = 1'b0;
      hdr_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhPrefix;
      off_q     <= 4'd0;
      pg_q      <= 1'b1;
      code_q    <= 16'd0;
      open_q    <= 1'b1;
      text_q    <= '0;
      name_q    <= '0;
      value_q   <= '0;
      cand_q    <= '1;
      chunk_q   <= 3'd0;
      lacc_q    <= 32'd0;
      num_q     <= NumLead;
      kept_q    <= 32'd0;
      chunked_q <= 1'b0;
      hdr_q     <= '0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      off_q     <= off_d;
      pg_q      <= pg_d;
      code_q    <= code_d;
      open_q    <= open_d;
      text_q    <= text_d;
      name_q    <= name_d;
      value_q   <= value_d;
      cand_q    <= cand_d;
      chunk_q   <= chunk_d;
      lacc_q    <= lacc_d;
      num_q     <= num_d;
      kept_q    <= kept_d;
      chunked_q <= chunked_d;
      hdr_q     <= hdr_d;
    end
  end

endmodule

### rtl/http_response_header_parser.sv
// path: a byte accepted into the input register goes on to the result register,
//   from which its result leaves
// throughput: one byte per cycle while res_o is not stalled; the parse state takes
//   its whole update for a byte as it moves from the input to the result register
// while a result waits, the input register takes one more byte and then stalls input
// reset: rst_ni clears the parse state and both valid flags asynchronously
module http_response_header_parser import hrhp_pkg::*; #(
  parameter int unsigned MAX_HEADERS       = MaxHeadersDef,
  parameter int unsigned NAME_BYTES        = NameBytesDef,
  parameter int unsigned VALUE_BYTES       = ValueBytesDef,
  parameter int unsigned STATUS_TEXT_BYTES = StatusTextBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrhp_in_if.sink    in_i,
  hrhp_out_if.source res_o
);

  `include "assert_macros.svh"

  localparam int unsigned SLOT_W = (MAX_HEADERS > 1) ? $clog2(MAX_HEADERS) : 1;
  localparam int unsigned HDR_W  = $clog2(MAX_HEADERS + 1);
  localparam int unsigned RES_W  = 3 + 8 + SLOT_W + 1 + 1 + 16 + 32 + 1 + HDR_W;

  logic              s1_valid;
  logic              s1_ready;
  logic [8:0]        s1_data;
  logic [2:0]        role;
  logic [SLOT_W-1:0] slot;
  logic              done;
  logic              err;
  logic [15:0]       code;
  logic [31:0]       length;
  logic              chunked;
  logic [HDR_W-1:0]  total;
  logic [RES_W-1:0]  res_d;
  logic [RES_W-1:0]  res_q;
  logic              summary_void;
  logic              summary_clear;
  logic              role_plain;

  hrhp_pipe_reg #(
    .W (9)
  ) u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  ({in_i.data_byte, in_i.last_byte}),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  hrhp_parse_core #(
    .MAX_HEADERS       (MAX_HEADERS),
    .NAME_BYTES        (NAME_BYTES),
    .VALUE_BYTES       (VALUE_BYTES),
    .STATUS_TEXT_BYTES (STATUS_TEXT_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (s1_valid && s1_ready),
    .byte_i    (s1_data[8:1]),
    .last_i    (s1_data[0]),
    .role_o    (role),
    .slot_o    (slot),
    .done_o    (done),
    .error_o   (err),
    .code_o    (code),
    .length_o  (length),
    .chunked_o (chunked),
    .total_o   (total)
  );

  assign res_d = {role, s1_data[8:1], slot, done, err, code, length, chunked, total};

  hrhp_pipe_reg #(
    .W (RES_W)
  ) u_res_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (res_d),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (res_q)
  );

  assign {res_o.byte_role, res_o.echo_byte, res_o.header_slot, res_o.done_res,
          res_o.parse_error, res_o.resp_code, res_o.body_length, res_o.chunked_seen,
          res_o.header_total} = res_q;

  assign summary_void  = !res_o.done_res || res_o.parse_error;
  assign summary_clear = res_o.resp_code == 16'd0 && res_o.body_length == 32'd0 &&
                         !res_o.chunked_seen && res_o.header_total == '0;
  assign role_plain    = res_o.byte_role == RoleNone || res_o.byte_role == RoleText;

  // summary fields only carry data on a clean end of block
  `HRHP_ASSERT(a_summary_idle, clk_i, rst_ni, res_o.valid && summary_void |-> summary_clear)
  `HRHP_ASSERT(a_error_at_done, clk_i, rst_ni, res_o.valid && res_o.parse_error |-> res_o.done_res)
  `HRHP_ASSERT(a_total_cap, clk_i, rst_ni, res_o.valid |-> res_o.header_total <= HDR_W'(MAX_HEADERS))
  `HRHP_NEVER(a_slot_plain, clk_i, rst_ni, res_o.valid && role_plain && res_o.header_slot != '0)

endmodule
